>>> hw/rtl/stpm_pkg.sv
package stpm_pkg;

    localparam int RANK      = 3;
    localparam int DIM_BITS  = 16;
    localparam int CORE_BITS = 10;

    localparam int NDIM       = 3;
    localparam int ADDR_W     = 48;
    localparam int CORE_IDX_W = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_DIM_W  = 16;
    localparam int CFG_CORE_W = 11;
    localparam int CNT_W      = (CFG_CORE_W > CORE_BITS + 1) ? CFG_CORE_W : CORE_BITS + 1;
    localparam int PROD2_W    = 2 * DIM_BITS;
    localparam int PROD3_W    = 3 * DIM_BITS;
    localparam int SETTLE_W   = 2;

    // two multiply stages behind the config registers
    localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = SETTLE_W'(2);

    localparam logic [CFG_IDX_W-1:0] REG_TENSOR_SIZE_0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TENSOR_SIZE_1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_TENSOR_SIZE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SHARD_SIZE_0  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_SHARD_SIZE_1  = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_SHARD_SIZE_2  = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_CORE_COUNT    = CFG_IDX_W'(6);

    typedef struct packed {
        logic [NDIM-1:0][DIM_BITS-1:0] tens;
        logic [NDIM-1:0][DIM_BITS-1:0] shard;
        logic [NDIM-1:0][DIM_BITS-1:0] first_ext;
        logic [ADDR_W-1:0]             tstride0;
        logic [ADDR_W-1:0]             tstride1;
        logic [ADDR_W-1:0]             sstride0;
        logic [ADDR_W-1:0]             sstride1;
        logic [ADDR_W-1:0]             jump0;
        logic [ADDR_W-1:0]             jump1;
        logic [ADDR_W-1:0]             vol;
        logic [CNT_W-1:0]              cores;
        logic                          empty;
    } t_derived;

    typedef struct packed {
        logic                  entry_valid;
        logic [CORE_IDX_W-1:0] core_index;
        logic [ADDR_W-1:0]     device_slot;
        logic [ADDR_W-1:0]     host_page;
        logic                  last_entry;
    } t_entry;

    function automatic logic [DIM_BITS-1:0] eff_tensor(int d, logic [CFG_DIM_W-1:0] v);
        if (d >= RANK) begin
            return DIM_BITS'(1);
        end
        return v[DIM_BITS-1:0];
    endfunction

    function automatic logic [DIM_BITS-1:0] eff_shard(int d, logic [CFG_DIM_W-1:0] v);
        logic [DIM_BITS-1:0] s;
        s = v[DIM_BITS-1:0];
        if (d >= RANK || s == '0) begin
            return DIM_BITS'(1);
        end
        return s;
    endfunction

    function automatic logic [CNT_W-1:0] eff_cores(logic [CFG_CORE_W-1:0] v);
        logic [CNT_W-1:0] c;
        logic [CNT_W-1:0] cmax;
        c    = CNT_W'(v);
        cmax = CNT_W'(1) << CORE_BITS;
        if (c == '0) begin
            return CNT_W'(1);
        end
        return (c > cmax) ? cmax : c;
    endfunction

    function automatic logic [DIM_BITS-1:0] min_dim(logic [DIM_BITS-1:0] a,
                                                    logic [DIM_BITS-1:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage

>>> hw/rtl/stpm_cfg.sv
module stpm_cfg import stpm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  logic [CFG_IDX_W-1:0]  i_idx,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_derived              o_der,
    output logic                  o_abort,
    output logic                  o_busy
);

    logic [NDIM-1:0][CFG_DIM_W-1:0] r_tens;
    logic [NDIM-1:0][CFG_DIM_W-1:0] r_shard;
    logic [CFG_CORE_W-1:0]          r_cores;
    logic [SETTLE_W-1:0]            r_settle;

    logic [NDIM-1:0][DIM_BITS-1:0]  w_t;
    logic [NDIM-1:0][DIM_BITS-1:0]  w_s;
    logic                           w_empty;
    logic                           w_known;

    logic [PROD2_W-1:0]             r_t12;
    logic [PROD2_W-1:0]             r_s12;
    logic [PROD2_W-1:0]             r_s1t2;
    logic [NDIM-1:0][DIM_BITS-1:0]  r_first_ext;
    logic [PROD3_W-1:0]             r_jump0;
    logic [PROD3_W-1:0]             r_vol;

    always_comb begin
        w_empty = 1'b0;
        for (int d = 0; d < NDIM; d++) begin
            w_t[d] = eff_tensor(d, r_tens[d]);
            w_s[d] = eff_shard(d, r_shard[d]);
            if (w_t[d] == '0) begin
                w_empty = 1'b1;
            end
        end
    end

    always_comb begin
        case (i_idx)
            REG_TENSOR_SIZE_0, REG_TENSOR_SIZE_1, REG_TENSOR_SIZE_2,
            REG_SHARD_SIZE_0, REG_SHARD_SIZE_1, REG_SHARD_SIZE_2,
            REG_CORE_COUNT: begin
                w_known = 1'b1;
            end
            default: begin
                w_known = 1'b0;
            end
        endcase
    end

    assign o_abort = i_wr && w_known;
    assign o_busy  = (r_settle != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tens   <= {NDIM{CFG_DIM_W'(1)}};
            r_shard  <= {NDIM{CFG_DIM_W'(1)}};
            r_cores  <= CFG_CORE_W'(1);
            r_settle <= SETTLE_CYCLES;
        end else begin
            if (i_wr) begin
                case (i_idx)
                    REG_TENSOR_SIZE_0: begin
                        r_tens[0] <= i_data[CFG_DIM_W-1:0];
                    end
                    REG_TENSOR_SIZE_1: begin
                        r_tens[1] <= i_data[CFG_DIM_W-1:0];
                    end
                    REG_TENSOR_SIZE_2: begin
                        r_tens[2] <= i_data[CFG_DIM_W-1:0];
                    end
                    REG_SHARD_SIZE_0: begin
                        r_shard[0] <= i_data[CFG_DIM_W-1:0];
                    end
                    REG_SHARD_SIZE_1: begin
                        r_shard[1] <= i_data[CFG_DIM_W-1:0];
                    end
                    REG_SHARD_SIZE_2: begin
                        r_shard[2] <= i_data[CFG_DIM_W-1:0];
                    end
                    REG_CORE_COUNT: begin
                        r_cores <= i_data[CFG_CORE_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (o_abort) begin
                r_settle <= SETTLE_CYCLES;
            end else if (r_settle != '0) begin
                r_settle <= r_settle - SETTLE_W'(1);
            end
        end
    end

    // stage 1: 16x16 products, stage 2: 16x32 products
    always_ff @(posedge i_clk) begin
        r_t12  <= w_t[1] * w_t[2];
        r_s12  <= w_s[1] * w_s[2];
        r_s1t2 <= w_s[1] * w_t[2];
        for (int d = 0; d < NDIM; d++) begin
            r_first_ext[d] <= min_dim(w_s[d], w_t[d]);
        end
        r_jump0 <= w_s[0] * r_t12;
        r_vol   <= w_s[0] * r_s12;
    end

    always_comb begin
        o_der.tens      = w_t;
        o_der.shard     = w_s;
        o_der.first_ext = r_first_ext;
        o_der.tstride0  = ADDR_W'(r_t12);
        o_der.tstride1  = ADDR_W'(w_t[2]);
        o_der.sstride0  = ADDR_W'(r_s12);
        o_der.sstride1  = ADDR_W'(w_s[2]);
        o_der.jump0     = ADDR_W'(r_jump0);
        o_der.jump1     = ADDR_W'(r_s1t2);
        o_der.vol       = ADDR_W'(r_vol);
        o_der.cores     = eff_cores(r_cores);
        o_der.empty     = w_empty;
    end

endmodule

>>> hw/rtl/stpm_walk.sv
module stpm_walk import stpm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  logic     i_restart,
    input  logic     i_abort,
    input  t_derived i_der,
    output t_entry   o_entry
);

    logic [NDIM-1:0][DIM_BITS-1:0] r_pc, r_ext, r_rem;
    logic [NDIM-1:0][DIM_BITS-1:0] w_pc, w_ext, w_rem;
    logic [NDIM-1:0][DIM_BITS-1:0] n_pc, n_ext, n_rem;
    logic [NDIM-1:0][DIM_BITS-1:0] w_rem_adv, w_ext_adv;
    logic [NDIM-1:0]               w_last, w_more;

    // host page: plane start, row start, current; shard base likewise
    logic [ADDR_W-1:0] r_host_p, r_host_r, r_host, w_host_p, w_host_r, w_host;
    logic [ADDR_W-1:0] n_host_p, n_host_r, n_host;
    logic [ADDR_W-1:0] r_shb_p, r_shb_r, r_shb, w_shb_p, w_shb_r, w_shb;
    logic [ADDR_W-1:0] n_shb_p, n_shb_r, n_shb;
    logic [ADDR_W-1:0] r_slot_base, r_slot_p, r_slot_r, r_slot;
    logic [ADDR_W-1:0] w_slot_base, w_slot_p, w_slot_r, w_slot;
    logic [ADDR_W-1:0] n_slot_base, n_slot_p, n_slot_r, n_slot;
    logic [CORE_BITS-1:0] r_core, w_core, n_core;
    logic [CNT_W-1:0]     w_core_inc;
    logic                 r_done, w_done, n_done;

    // walk state as seen by this item (freshly started on restart)
    always_comb begin
        if (i_restart) begin
            w_pc        = '0;
            w_ext       = i_der.first_ext;
            w_rem       = i_der.tens;
            w_host_p    = '0;
            w_host_r    = '0;
            w_host      = '0;
            w_shb_p     = '0;
            w_shb_r     = '0;
            w_shb       = '0;
            w_slot_base = '0;
            w_slot_p    = '0;
            w_slot_r    = '0;
            w_slot      = '0;
            w_core      = '0;
            w_done      = i_der.empty;
        end else begin
            w_pc        = r_pc;
            w_ext       = r_ext;
            w_rem       = r_rem;
            w_host_p    = r_host_p;
            w_host_r    = r_host_r;
            w_host      = r_host;
            w_shb_p     = r_shb_p;
            w_shb_r     = r_shb_r;
            w_shb       = r_shb;
            w_slot_base = r_slot_base;
            w_slot_p    = r_slot_p;
            w_slot_r    = r_slot_r;
            w_slot      = r_slot;
            w_core      = r_core;
            w_done      = r_done;
        end
    end

    always_comb begin
        for (int d = 0; d < NDIM; d++) begin
            w_last[d]    = (w_pc[d] == w_ext[d] - DIM_BITS'(1));
            w_more[d]    = (w_rem[d] > i_der.shard[d]);
            w_rem_adv[d] = w_rem[d] - i_der.shard[d];
            w_ext_adv[d] = min_dim(i_der.shard[d], w_rem_adv[d]);
        end
        w_core_inc = CNT_W'(w_core) + CNT_W'(1);
    end

    always_comb begin
        n_pc        = w_pc;
        n_ext       = w_ext;
        n_rem       = w_rem;
        n_host_p    = w_host_p;
        n_host_r    = w_host_r;
        n_host      = w_host;
        n_shb_p     = w_shb_p;
        n_shb_r     = w_shb_r;
        n_shb       = w_shb;
        n_slot_base = w_slot_base;
        n_slot_p    = w_slot_p;
        n_slot_r    = w_slot_r;
        n_slot      = w_slot;
        n_core      = w_core;
        n_done      = w_done;
        if (!w_done) begin
            if (!w_last[2]) begin
                n_pc[2] = w_pc[2] + DIM_BITS'(1);
                n_host  = w_host + ADDR_W'(1);
                n_slot  = w_slot + ADDR_W'(1);
            end else if (!w_last[1]) begin
                n_pc[2]  = '0;
                n_pc[1]  = w_pc[1] + DIM_BITS'(1);
                n_host_r = w_host_r + i_der.tstride1;
                n_host   = n_host_r;
                n_slot_r = w_slot_r + i_der.sstride1;
                n_slot   = n_slot_r;
            end else if (!w_last[0]) begin
                n_pc[2]  = '0;
                n_pc[1]  = '0;
                n_pc[0]  = w_pc[0] + DIM_BITS'(1);
                n_host_p = w_host_p + i_der.tstride0;
                n_host_r = n_host_p;
                n_host   = n_host_p;
                n_slot_p = w_slot_p + i_der.sstride0;
                n_slot_r = n_slot_p;
                n_slot   = n_slot_p;
            end else begin
                n_pc = '0;
                if (w_more[2]) begin
                    n_rem[2] = w_rem_adv[2];
                    n_ext[2] = w_ext_adv[2];
                    n_shb    = w_shb + i_der.sstride1;
                end else if (w_more[1]) begin
                    n_rem[2] = i_der.tens[2];
                    n_ext[2] = i_der.first_ext[2];
                    n_rem[1] = w_rem_adv[1];
                    n_ext[1] = w_ext_adv[1];
                    n_shb_r  = w_shb_r + i_der.jump1;
                    n_shb    = n_shb_r;
                end else if (w_more[0]) begin
                    n_rem[2] = i_der.tens[2];
                    n_ext[2] = i_der.first_ext[2];
                    n_rem[1] = i_der.tens[1];
                    n_ext[1] = i_der.first_ext[1];
                    n_rem[0] = w_rem_adv[0];
                    n_ext[0] = w_ext_adv[0];
                    n_shb_p  = w_shb_p + i_der.jump0;
                    n_shb_r  = n_shb_p;
                    n_shb    = n_shb_p;
                end else begin
                    n_done = 1'b1;
                end
                if (!n_done) begin
                    n_host_p = n_shb;
                    n_host_r = n_shb;
                    n_host   = n_shb;
                    if (w_core_inc >= i_der.cores) begin
                        n_core      = '0;
                        n_slot_base = w_slot_base + i_der.vol;
                    end else begin
                        n_core = w_core_inc[CORE_BITS-1:0];
                    end
                    n_slot_p = n_slot_base;
                    n_slot_r = n_slot_base;
                    n_slot   = n_slot_base;
                end
            end
        end
    end

    always_comb begin
        o_entry.entry_valid = !w_done;
        o_entry.core_index  = w_done ? '0 : CORE_IDX_W'(w_core);
        o_entry.device_slot = w_done ? '0 : w_slot;
        o_entry.host_page   = w_done ? '0 : w_host;
        o_entry.last_entry  = !w_done && n_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b1;
        end else if (i_abort) begin
            r_done <= 1'b1;
        end else if (i_step) begin
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_pc        <= n_pc;
            r_ext       <= n_ext;
            r_rem       <= n_rem;
            r_host_p    <= n_host_p;
            r_host_r    <= n_host_r;
            r_host      <= n_host;
            r_shb_p     <= n_shb_p;
            r_shb_r     <= n_shb_r;
            r_shb       <= n_shb;
            r_slot_base <= n_slot_base;
            r_slot_p    <= n_slot_p;
            r_slot_r    <= n_slot_r;
            r_slot      <= n_slot;
            r_core      <= n_core;
        end
    end

endmodule

>>> hw/rtl/sharded_tensor_page_map_generator.sv
// Page-map address generator for a sharded tensor: each request item (restart or next)
// returns one mapping entry (core, slot on that core, host page), walking shards in
// row-major order and pages within each shard, shards dealt round robin over the cores.
// Throughput is one item per cycle whenever the result side takes results and no config
// products are settling; the next entry is formed from nested page and shard counters
// with incremental 48-bit base adders, and a result register decouples the two sides.
// After reset and after every accepted write to a defined configuration register,
// o_in_ready is low while the stride and shard-volume products settle in a two-stage
// multiplier; such a write ends any walk in progress, and a restart item begins anew.
module sharded_tensor_page_map_generator import stpm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_restart,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_entry_valid,
    output logic [CORE_IDX_W-1:0] o_core_index,
    output logic [ADDR_W-1:0]     o_device_slot,
    output logic [ADDR_W-1:0]     o_host_page,
    output logic                  o_last_entry
);

    t_derived w_der;
    t_entry   w_entry;
    t_entry   r_out;
    logic     r_out_valid;
    logic     w_abort;
    logic     w_busy;
    logic     w_in_acc;

    assign o_cfg_ready = 1'b1;

    stpm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_idx   (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_der   (w_der),
        .o_abort (w_abort),
        .o_busy  (w_busy)
    );

    assign o_in_ready = !w_busy && (!r_out_valid || i_out_ready);
    assign w_in_acc   = i_in_valid && o_in_ready;

    stpm_walk u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_in_acc),
        .i_restart (i_restart),
        .i_abort   (w_abort),
        .i_der     (w_der),
        .o_entry   (w_entry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_out <= w_entry;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_entry_valid = r_out.entry_valid;
    assign o_core_index  = r_out.core_index;
    assign o_device_slot = r_out.device_slot;
    assign o_host_page   = r_out.host_page;
    assign o_last_entry  = r_out.last_entry;

    a_cfg_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready && (i_cfg_index <= REG_CORE_COUNT) |=> !o_in_ready)
        else $error("input taken while config products settle");

    a_item_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_out_valid)
        else $error("accepted item produced no result");

    a_last_is_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_entry |-> o_entry_valid)
        else $error("last flag on an empty entry");

    a_empty_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_entry_valid |->
            (o_core_index == '0) && (o_device_slot == '0) && (o_host_page == '0))
        else $error("empty entry carries nonzero payload");

endmodule
